@@ sv/cfsc_pkg.sv @@
package cfsc_pkg;

	// data and time sizing
	localparam int DATA_BITS = 32;
	localparam int TIME_BITS = 31;
	localparam int TS_W      = 31;
	localparam int WORD_W    = 32;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0]  FRAME_BITS_RESET = CNT_W'(24);
	localparam logic [WORD_W-1:0] ALL_ONES         = {WORD_W{1'b1}};
	localparam logic [TS_W-1:0]   TIME_MASK        = TS_W'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [CNT_W-1:0]  DATA_BITS_CNT    = CNT_W'(DATA_BITS);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_BITS       = 2'd0,
		REG_MAX_CLOCK_PERIOD = 2'd1,
		REG_MIN_START_GAP    = 2'd2,
		REG_MAX_START_GAP    = 2'd3
	} reg_idx_t;

	// input item
	typedef struct packed {
		logic            cmd;
		logic [TS_W-1:0] timestamp;
		logic            data_level;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [WORD_W-1:0] frame_data;
		logic [WORD_W-1:0] fastest_period;
		logic [WORD_W-1:0] slowest_period;
		logic [WORD_W-1:0] first_gap;
		logic [CNT_W-1:0]  bits_taken;
		logic              ready_res;
	} res_item_t;

	// configuration registers as seen by the capture logic
	typedef struct packed {
		logic [CNT_W-1:0]  frame_bits;
		logic [WORD_W-1:0] max_clock_period;
		logic [WORD_W-1:0] min_start_gap;
		logic [WORD_W-1:0] max_start_gap;
	} cfg_t;

endpackage

@@ sv/clocked_serial_frame_capture.sv @@
// an input transfer reaches the result side through the input register and then the result
// register
// throughput: one item per cycle while the result is not stalled; the capture state is updated once per item
// a stalled result holds the result register and, behind it, the input register
// reset: asynchronous, active low; clears capture state and handshake valids,
// frame_bits returns to 24 and the other registers to zero
module clocked_serial_frame_capture (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfsc_pkg::WORD_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cfsc_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cfsc_pkg::res_item_t             out_item
);

	cfsc_pkg::cfg_t      cfg;
	cfsc_pkg::in_item_t  item_s1;
	cfsc_pkg::res_item_t res_nxt;
	cfsc_pkg::res_item_t res_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                advance;
	logic                step;

	// pipeline control
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	cfsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.res    (res_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	// no state update while a result is stalled
	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |-> !step)
		else $error("capture state advanced while result stalled");

	// an accepted transfer always lands in the input register
	a_input_captured: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted transfer lost");

	// a complete frame has at least one bit
	a_ready_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.ready_res) |-> (out_item.bits_taken != '0))
		else $error("frame complete with no bits");

	// bit count never passes the data width
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.bits_taken <= cfsc_pkg::DATA_BITS_CNT))
		else $error("bit count beyond data width");

endmodule

@@ sv/cfsc_cfg.sv @@
module cfsc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cfsc_pkg::WORD_W-1:0]         cfg_data,
	output cfsc_pkg::cfg_t                      cfg
);

	cfsc_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_bits       <= cfsc_pkg::FRAME_BITS_RESET;
			cfg_q.max_clock_period <= '0;
			cfg_q.min_start_gap    <= '0;
			cfg_q.max_start_gap    <= '0;
		end else if (cfg_we) begin
			case (cfsc_pkg::reg_idx_t'(cfg_index))
				cfsc_pkg::REG_FRAME_BITS: begin
					cfg_q.frame_bits <= cfg_data[cfsc_pkg::CNT_W-1:0];
				end
				cfsc_pkg::REG_MAX_CLOCK_PERIOD: begin
					cfg_q.max_clock_period <= cfg_data;
				end
				cfsc_pkg::REG_MIN_START_GAP: begin
					cfg_q.min_start_gap <= cfg_data;
				end
				cfsc_pkg::REG_MAX_START_GAP: begin
					cfg_q.max_start_gap <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/cfsc_core.sv @@
module cfsc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfsc_pkg::cfg_t       cfg,
	input  logic                 step,
	input  cfsc_pkg::in_item_t   item,
	output cfsc_pkg::res_item_t  res
);

	// capture state
	logic [cfsc_pkg::TS_W-1:0]      last_time_q, last_time_nxt;
	logic [cfsc_pkg::DATA_BITS-1:0] shift_q, shift_nxt;
	logic [cfsc_pkg::CNT_W-1:0]     idx_q, idx_nxt;
	logic [cfsc_pkg::WORD_W-1:0]    min_q, min_nxt;
	logic [cfsc_pkg::WORD_W-1:0]    max_q, max_nxt;
	logic [cfsc_pkg::WORD_W-1:0]    gap_q, gap_nxt;
	logic                           done_q, done_nxt;

	logic [cfsc_pkg::TS_W-1:0]      now;
	logic [cfsc_pkg::WORD_W-1:0]    period;
	logic                           out_window;
	logic                           too_slow;
	logic                           restart;
	logic [cfsc_pkg::CNT_W-1:0]     limit;
	logic [cfsc_pkg::CNT_W-1:0]     cur_idx;
	logic [cfsc_pkg::DATA_BITS-1:0] base_data;

	// period and qualification
	assign now        = item.timestamp & cfsc_pkg::TIME_MASK;
	assign period     = cfsc_pkg::WORD_W'(now) - cfsc_pkg::WORD_W'(last_time_q);
	assign out_window = (period < cfg.min_start_gap) || (period > cfg.max_start_gap);
	assign too_slow   = period > cfg.max_clock_period;
	assign restart    = (idx_q == '0) || too_slow;
	assign limit      = (cfg.frame_bits > cfsc_pkg::DATA_BITS_CNT) ?
		cfsc_pkg::DATA_BITS_CNT : cfg.frame_bits;
	assign cur_idx    = restart ? '0 : idx_q;
	assign base_data  = restart ? '0 : shift_q;

	// next state
	always_comb begin
		last_time_nxt = last_time_q;
		shift_nxt     = shift_q;
		idx_nxt       = idx_q;
		min_nxt       = min_q;
		max_nxt       = max_q;
		gap_nxt       = gap_q;
		done_nxt      = done_q;
		if (item.cmd) begin
			shift_nxt = '0;
			idx_nxt   = '0;
			min_nxt   = cfsc_pkg::ALL_ONES;
			max_nxt   = '0;
			done_nxt  = 1'b0;
		end else if (!done_q) begin
			last_time_nxt = now;
			if (!((idx_q == '0) && out_window)) begin
				if (restart) begin
					min_nxt = cfsc_pkg::ALL_ONES;
					max_nxt = '0;
					gap_nxt = period;
				end else begin
					if (period < min_q) begin
						min_nxt = period;
					end
					if (period > max_q) begin
						max_nxt = period;
					end
				end
				// bits past the data width shift out to nothing
				shift_nxt = base_data | (cfsc_pkg::DATA_BITS'(item.data_level) << cur_idx);
				idx_nxt   = cur_idx + cfsc_pkg::CNT_W'(1);
				done_nxt  = idx_nxt >= limit;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			shift_q     <= '0;
			idx_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			gap_q       <= '0;
			done_q      <= 1'b0;
		end else if (step) begin
			last_time_q <= last_time_nxt;
			shift_q     <= shift_nxt;
			idx_q       <= idx_nxt;
			min_q       <= min_nxt;
			max_q       <= max_nxt;
			gap_q       <= gap_nxt;
			done_q      <= done_nxt;
		end
	end

	// result shows the state after the transfer
	assign res.frame_data     = cfsc_pkg::WORD_W'(shift_nxt);
	assign res.fastest_period = min_nxt;
	assign res.slowest_period = max_nxt;
	assign res.first_gap      = gap_nxt;
	assign res.bits_taken     = idx_nxt;
	assign res.ready_res      = done_nxt;

endmodule

@@ test/cfsc_checker.sv @@
module capture_checker
	import cfsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  res_item_t            out_item,
	output int                   pending,
	output int                   mismatches,
	output int                   results_seen,
	output int                   frames_done
);

	// shadow copy of the configuration registers
	logic [CNT_W-1:0]  frame_bits_c;
	logic [WORD_W-1:0] max_period_c;
	logic [WORD_W-1:0] min_gap_c;
	logic [WORD_W-1:0] max_gap_c;

	// shadow copy of the capture state
	logic [TS_W-1:0]   last_edge;
	logic [WORD_W-1:0] shreg;
	logic [WORD_W-1:0] fastest;
	logic [WORD_W-1:0] slowest;
	logic [WORD_W-1:0] gap_seen;
	logic [CNT_W-1:0]  taken;
	logic              complete;

	// capture snapshots still owed by the block, oldest first
	res_item_t snapshots[$];

	task automatic restart_frame();
		shreg   = '0;
		taken   = '0;
		fastest = ALL_ONES;
		slowest = '0;
	endtask

	// advance the capture state by one transfer and return the snapshot it shows
	task automatic step_capture(input in_item_t it, output res_item_t snap);
		logic [TS_W-1:0]   now;
		logic [WORD_W-1:0] period;
		logic [CNT_W-1:0]  limit;
		logic              take;
		now  = it.timestamp & TIME_MASK;
		take = 1'b0;
		if (it.cmd) begin
			restart_frame();
			complete = 1'b0;
		end else if (!complete) begin
			period = WORD_W'(now) - WORD_W'(last_edge);
			take   = 1'b1;
			if (taken == '0) begin
				// first bit only inside the start window, else just note the time
				if (period < min_gap_c || period > max_gap_c) begin
					take = 1'b0;
				end else begin
					restart_frame();
					gap_seen = period;
				end
			end else if (period > max_period_c) begin
				// overlong bit period: drop the frame, this edge starts a new one
				restart_frame();
				gap_seen = period;
			end else begin
				if (period < fastest) fastest = period;
				if (period > slowest) slowest = period;
			end
			last_edge = now;
			if (take) begin
				if (taken < DATA_BITS_CNT) shreg = shreg | (WORD_W'(it.data_level) << taken);
				taken = taken + 1'b1;
				limit = (frame_bits_c > DATA_BITS_CNT) ? DATA_BITS_CNT : frame_bits_c;
				if (taken >= limit) begin
					complete = 1'b1;
					frames_done++;
				end
			end
		end
		snap = '{frame_data: shreg, fastest_period: fastest, slowest_period: slowest,
			first_gap: gap_seen, bits_taken: taken, ready_res: complete};
	endtask

	task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
		input logic [WORD_W-1:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	// watch the channels: compare results, track writes, predict on input transfers
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		res_item_t snap;
		if (!arst_n) begin
			frame_bits_c = FRAME_BITS_RESET;
			max_period_c = '0;
			min_gap_c    = '0;
			max_gap_c    = '0;
			last_edge    = '0;
			shreg        = '0;
			fastest      = '0;
			slowest      = '0;
			gap_seen     = '0;
			taken        = '0;
			complete     = 1'b0;
			snapshots.delete();
			pending      = 0;
		end else begin
			// result transfer
			if (out_valid && out_ready) begin
				results_seen++;
				if (snapshots.size() == 0) begin
					flag_mismatch("unexpected result frame_data", out_item.frame_data, '0);
				end else begin
					want = snapshots.pop_front();
					if (out_item.frame_data !== want.frame_data)
						flag_mismatch("frame_data", out_item.frame_data, want.frame_data);
					if (out_item.fastest_period !== want.fastest_period)
						flag_mismatch("fastest_period", out_item.fastest_period,
							want.fastest_period);
					if (out_item.slowest_period !== want.slowest_period)
						flag_mismatch("slowest_period", out_item.slowest_period,
							want.slowest_period);
					if (out_item.first_gap !== want.first_gap)
						flag_mismatch("first_gap", out_item.first_gap, want.first_gap);
					if (out_item.bits_taken !== want.bits_taken)
						flag_mismatch("bits_taken", out_item.bits_taken, want.bits_taken);
					if (out_item.ready_res !== want.ready_res)
						flag_mismatch("ready_res", out_item.ready_res, want.ready_res);
				end
			end
			// register write
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_FRAME_BITS:       frame_bits_c = cfg_data[CNT_W-1:0];
					REG_MAX_CLOCK_PERIOD: max_period_c = cfg_data;
					REG_MIN_START_GAP:    min_gap_c    = cfg_data;
					REG_MAX_START_GAP:    max_gap_c    = cfg_data;
					default: ;
				endcase
			end
			// input transfer
			if (in_valid && in_ready) begin
				step_capture(in_item, snap);
				snapshots.push_back(snap);
			end
			pending = snapshots.size();
		end
	end

endmodule

@@ test/testbench.sv @@
module testbench;
	import cfsc_pkg::*;

	localparam int ITEM_TARGET   = 1250;
	localparam int PHASE_ITEMS   = 150;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 6;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	res_item_t            out_item;

	int pending;
	int mismatches;
	int results_seen;
	int frames_done;

	int cycle_count;
	int items_sent;
	int arms_sent;
	int settings_used;
	int counted;
	int burst_left;

	// what the stimulus believes about the block
	logic [TS_W-1:0]   prev_t;
	logic [CNT_W-1:0]  fb_cur;
	logic [WORD_W-1:0] mcp_cur;
	logic [WORD_W-1:0] ming_cur;
	logic [WORD_W-1:0] maxg_cur;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_phase = 0;

	always #1 clk = ~clk;

	clocked_serial_frame_capture dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	capture_checker scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item),
		.pending      (pending),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.frames_done  (frames_done)
	);

	// result side back-pressure, switching between stall patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: out_ready <= (rx_phase % 4 == 0);
			default:     out_ready <= ($urandom_range(0, 11) == 0);
		endcase
	end

	// one input transfer, sent in bursts with idle gaps between them
	task automatic transfer_item(input logic c, input logic [TS_W-1:0] ts, input logic lvl);
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		in_item  <= '{cmd: c, timestamp: ts, data_level: lvl};
		burst_left--;
		items_sent++;
		if (c) arms_sent++;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// transfer that the block acts on; edges move the believed last edge time
	task automatic feed(input logic c, input logic [TS_W-1:0] ts, input logic lvl);
		transfer_item(c, ts, lvl);
		counted++;
		if (!c) prev_t = ts;
	endtask

	// registers only change once the block has drained
	task automatic write_settings(input logic [CNT_W-1:0] fb, input logic [WORD_W-1:0] mcp,
		input logic [WORD_W-1:0] ming, input logic [WORD_W-1:0] maxg);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_BITS;
		cfg_data  <= {(WORD_W-CNT_W)'($urandom), fb};
		@(negedge clk);
		cfg_index <= REG_MAX_CLOCK_PERIOD;
		cfg_data  <= mcp;
		@(negedge clk);
		cfg_index <= REG_MIN_START_GAP;
		cfg_data  <= ming;
		@(negedge clk);
		cfg_index <= REG_MAX_START_GAP;
		cfg_data  <= maxg;
		@(negedge clk);
		cfg_we <= 1'b0;
		fb_cur   = fb;
		mcp_cur  = mcp;
		ming_cur = ming;
		maxg_cur = maxg;
		settings_used++;
		burst_left = 0;
	endtask

	// random setting with a bias towards the extremes
	task automatic pick_settings();
		logic [CNT_W-1:0]  fb;
		logic [WORD_W-1:0] mcp;
		logic [WORD_W-1:0] ming;
		logic [WORD_W-1:0] maxg;
		case ($urandom_range(0, 9))
			0:       fb = '0;
			1:       fb = CNT_W'(1);
			2:       fb = DATA_BITS_CNT;
			3:       fb = CNT_W'(33);
			4:       fb = '1;
			5:       fb = FRAME_BITS_RESET;
			6, 7:    fb = CNT_W'($urandom_range(2, 8));
			default: fb = CNT_W'($urandom_range(1, 32));
		endcase
		case ($urandom_range(0, 5))
			0:       mcp = '0;
			1:       mcp = ALL_ONES;
			2:       mcp = $urandom;
			default: mcp = $urandom_range(1, 3000);
		endcase
		case ($urandom_range(0, 7))
			0:       ming = '0;
			1:       ming = ALL_ONES;
			2:       ming = $urandom;
			default: ming = $urandom_range(0, 2000);
		endcase
		case ($urandom_range(0, 7))
			0:       maxg = ALL_ONES;
			1:       maxg = ming;
			2:       maxg = ming - 1'b1;
			3:       maxg = '0;
			default: maxg = ming + $urandom_range(0, 5000);
		endcase
		write_settings(fb, mcp, ming, maxg);
	endtask

	// silence before the first bit, inside the window where there is one
	function automatic logic [WORD_W-1:0] start_gap_pick();
		logic [WORD_W-1:0] span;
		if (ming_cur > maxg_cur) return WORD_W'($urandom_range(0, 5000));
		span = maxg_cur - ming_cur;
		if (span > 20000) span = 20000;
		return ming_cur + WORD_W'($urandom_range(0, span));
	endfunction

	// silence that misses the window, to pin down the last edge time
	function automatic logic [WORD_W-1:0] miss_gap_pick();
		logic [WORD_W-1:0] reach;
		if (maxg_cur < 32'hFFFF_0000) return maxg_cur + 1'b1 + $urandom_range(0, 1000);
		if (ming_cur == '0) return WORD_W'($urandom_range(0, 5000));
		reach = (ming_cur > 1000) ? 1000 : ming_cur;
		return ming_cur - WORD_W'($urandom_range(1, reach));
	endfunction

	// bit period inside the clock limit, now and then an overlong one
	function automatic logic [WORD_W-1:0] bit_period_pick();
		logic [WORD_W-1:0] cap;
		if ($urandom_range(0, 24) == 0 && mcp_cur < 32'hFFFF_0000)
			return mcp_cur + 1'b1 + $urandom_range(0, 100);
		cap = (mcp_cur > 3000) ? 3000 : mcp_cur;
		return WORD_W'($urandom_range(0, cap));
	endfunction

	function automatic logic [TS_W-1:0] after(input logic [WORD_W-1:0] gap);
		return TS_W'(WORD_W'(prev_t) + gap);
	endfunction

	task automatic noise_item();
		feed(1'($urandom_range(0, 1)), TS_W'($urandom), 1'($urandom));
	endtask

	// arm, start bit in the window, the rest of the frame, then a few ignored edges
	task automatic run_frame();
		int nb;
		nb = (fb_cur == '0) ? 1 : (fb_cur > DATA_BITS_CNT) ? DATA_BITS : int'(fb_cur);
		if ($urandom_range(0, 9) != 0) feed(1'b1, TS_W'($urandom), 1'($urandom));
		if ($urandom_range(0, 9) < 6) feed(1'b0, after(miss_gap_pick()), 1'($urandom));
		feed(1'b0, after(start_gap_pick()), 1'($urandom));
		for (int i = 1; i < nb; i++) begin
			if ($urandom_range(0, 39) == 0) noise_item();
			feed(1'b0, after(bit_period_pick()), 1'($urandom));
		end
		repeat ($urandom_range(0, 2)) transfer_item(1'b0, TS_W'($urandom), 1'($urandom));
	endtask

	// run time limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench failed");
		$finish;
	end

	initial begin
		int phase_start;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_FRAME_BITS;
		cfg_data      = '0;
		in_valid      = 1'b0;
		in_item       = '0;
		items_sent    = 0;
		arms_sent     = 0;
		settings_used = 1;
		counted       = 0;
		burst_left    = 0;
		prev_t        = '0;
		fb_cur        = FRAME_BITS_RESET;
		mcp_cur       = '0;
		ming_cur      = '0;
		maxg_cur      = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: edges before any arm, zero-width window, abort on any delay
		feed(1'b0, 31'd0, 1'b1);
		feed(1'b0, 31'd0, 1'b0);
		feed(1'b0, 31'd0, 1'b1);
		feed(1'b0, 31'd3, 1'b1);
		feed(1'b1, 31'h7FFF_FFFF, 1'b1);
		feed(1'b0, 31'd9, 1'b1);
		feed(1'b0, 31'd9, 1'b1);

		// one-bit frames, open window, widest timestamp and wrap back to zero
		write_settings(CNT_W'(1), ALL_ONES, '0, ALL_ONES);
		feed(1'b1, 31'd0, 1'b0);
		feed(1'b0, 31'h7FFF_FFFF, 1'b1);
		feed(1'b0, 31'd5, 1'b0);
		feed(1'b1, 31'd0, 1'b0);
		feed(1'b0, 31'd0, 1'b0);

		// zero frame length, window pinned at all ones, timestamp stepping back by one
		write_settings('0, '0, ALL_ONES, ALL_ONES);
		feed(1'b1, 31'd0, 1'b0);
		feed(1'b0, 31'd10, 1'b0);
		feed(1'b0, 31'd9, 1'b1);

		// empty start window: edges only move the last edge time
		write_settings('1, ALL_ONES, WORD_W'(5), WORD_W'(4));
		feed(1'b1, 31'd0, 1'b1);
		feed(1'b0, 31'd20, 1'b1);
		feed(1'b0, 31'd25, 1'b0);

		// random phases
		pick_settings();
		phase_start = counted;
		while (counted < ITEM_TARGET) begin
			if (counted - phase_start >= PHASE_ITEMS) begin
				pick_settings();
				phase_start = counted;
			end
			run_frame();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d input transfers (%0d arms) over %0d register settings",
			items_sent, arms_sent, settings_used);
		$display("%0d results checked, %0d frames captured to completion, %0d mismatches",
			results_seen, frames_done, mismatches);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
